@@ rtl/deq_pkg.sv @@
// deq_pkg: shared types, sizes and helpers for the double-ended queue
// no dependencies; imported by every module of the block except deq_ram
package deq_pkg;

   // sizes
   localparam int DEPTH  = 8;
   localparam int DATA_W = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int OCC_W  = 4;

   // requested action codes
   typedef enum logic [1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_PUSH_BACK  = 2'd1,
      ACT_POP_FRONT  = 2'd2,
      ACT_POP_BACK   = 2'd3
   } action_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // input item
   typedef struct packed {
      action_type                action;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   // result item
   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  popped_value;
      logic [OCC_W-1:0]          occupancy;
   } rsp_type;

   // commands from controller to datapath
   typedef struct packed {
      logic take_item;
      logic load_rsp;
   } cmd_type;

   // fold a sum below twice the depth back onto a slot index
   function automatic logic [ADDR_W-1:0] slot_wrap(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] folded;
      folded = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
      return folded[ADDR_W-1:0];
   endfunction

endpackage

@@ rtl/double_ended_queue.sv @@
// double_ended_queue: top level of the circular-buffer deque
// depends on deq_pkg, deq_ctrl and deq_dp
//
// usage
// - req channel: req_valid/req_stall/req_data carry one action (push front,
//   push back, pop front, pop back) and a value used only by pushes
// - rsp channel: rsp_valid/rsp_stall/rsp_data carry one result per action:
//   status (ok, full, empty), the popped value (zero unless a pop succeeds)
//   and the number of entries held after the action
// - an action updates head and count at the cycle of its transfer; pops
//   read the entry ram there and the result register loads in the exec
//   state that follows, once the output register is free
// - one item is in work at a time, set by the registered read port of
//   the entry ram; the request side stays stalled while an item is in work
// - a finished result waits in the output register while the next request
//   is taken; if rsp_stall holds past that, the next item waits in work
//   and req_stall stays high until the output register frees up
// - reset empties the queue (head and count cleared) and drops rsp_valid;
//   entry contents are not cleared, as only written slots are ever read
module double_ended_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::rsp_type rsp_data
);
   import deq_pkg::*;

   cmd_type cmd;

   // sequencing
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // storage and pointers
   deq_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

@@ rtl/deq_ram.sv @@
// deq_ram: generic single write port, single read port ram
// registered read data; no dependencies
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/deq_ctrl.sv @@
// deq_ctrl: sequencing state machine and result valid for the queue
// depends on deq_pkg
module deq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::cmd_type cmd
);
   import deq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take_item;
   logic      out_free;
   logic      load_rsp;

   // handshake decode
   assign req_stall = (state_ff != S_IDLE);
   assign take_item = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = (state_ff == S_EXEC) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (take_item) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid holds until the transfer
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign cmd.take_item = take_item;
   assign cmd.load_rsp  = load_rsp;

endmodule

@@ rtl/deq_dp.sv @@
// deq_dp: head and count registers, entry ram and result register
// depends on deq_pkg and deq_ram
module deq_dp (
   input  logic             clock,
   input  logic             reset,
   input  deq_pkg::cmd_type cmd,
   input  deq_pkg::req_type req_data,
   output deq_pkg::rsp_type rsp_data
);
   import deq_pkg::*;

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   status_type        status_ff, status_in;
   logic              pop_ok_ff, pop_ok_in;
   rsp_type           rsp_ff, rsp_in;

   logic              full, empty;
   logic [ADDR_W-1:0] front_prev, head_next;
   logic [SUM_W-1:0]  sum_tail, sum_last;
   logic [ADDR_W-1:0] tail_slot, last_slot;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] rd_data;

   // slot arithmetic
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign front_prev = (head_ff == '0) ? ADDR_W'(DEPTH - 1) : head_ff - ADDR_W'(1);
   assign head_next  = (head_ff == ADDR_W'(DEPTH - 1)) ? '0 : head_ff + ADDR_W'(1);
   assign sum_tail   = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign sum_last   = sum_tail - SUM_W'(1);
   assign tail_slot  = slot_wrap(sum_tail);
   assign last_slot  = slot_wrap(sum_last);

   // action decode on an accepted item
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = status_ff;
      pop_ok_in = pop_ok_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_slot;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      if (cmd.take_item) begin
         status_in = ST_OK;
         pop_ok_in = 1'b0;
         case (req_data.action)
            ACT_PUSH_FRONT: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = front_prev;
                  head_in  = front_prev;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ACT_PUSH_BACK: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_slot;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ACT_POP_FRONT: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = head_ff;
                  head_in   = head_next;
                  count_in  = count_ff - CNT_W'(1);
                  pop_ok_in = 1'b1;
               end
            end
            ACT_POP_BACK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = last_slot;
                  count_in  = count_ff - CNT_W'(1);
                  pop_ok_in = 1'b1;
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   // entry store
   deq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result register, loaded once the read data is back
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.status       = status_ff;
         rsp_in.popped_value = pop_ok_ff ? $signed(rd_data) : '0;
         rsp_in.occupancy    = OCC_W'(count_ff);
      end
   end

   // pointer state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      pop_ok_ff <= pop_ok_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

@@ rtl/deq_checker.sv @@
// deq_checker: port-level checks for double_ended_queue, bound to the top
// depends on deq_pkg
module deq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input deq_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input deq_pkg::rsp_type rsp_data
);
   import deq_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one item in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while an item is in work");

   // a refused push only when the queue is full
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |->
         rsp_data.occupancy == OCC_W'(DEPTH) && rsp_data.popped_value == '0)
      else $error("full status with wrong occupancy or value");

   // a refused pop only when the queue is empty
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |->
         rsp_data.occupancy == '0 && rsp_data.popped_value == '0)
      else $error("empty status with wrong occupancy or value");

   logic unused_req;
   assign unused_req = ^req_data;

endmodule

bind double_ended_queue deq_checker u_deq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
